FILE: design/glyph_text_pixel_generator_top_defines.svh
// Assertion macros shared by the glyph text pixel generator RTL.
// No dependencies; included by the top level.
`ifndef GLYPH_TEXT_PIXEL_GENERATOR_TOP_DEFINES_SVH
`define GLYPH_TEXT_PIXEL_GENERATOR_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define GTPG_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gtpg same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define GTPG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gtpg next-cycle check failed");

`endif

FILE: design/gtpg_pkg.sv
// Types, constants, glyph ROM and coordinate helpers for the glyph text pixel generator.
// No dependencies; used by every module of the block.
`default_nettype none

package gtpg_pkg;

   localparam int COORD_BITS  = 12;
   localparam int GLYPH_BITS  = 15;
   localparam int GLYPH_COUNT = 40;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 4;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_INK_BLACK = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ROTATION  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CHAR_GAP  = 2'd2;

   localparam logic [1:0] ROT_UPRIGHT = 2'd0;
   localparam logic [1:0] ROT_90      = 2'd1;
   localparam logic [1:0] ROT_270     = 2'd2;

   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_Z = 8'h7A;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_COLON   = 8'h3A;
   localparam logic [7:0] CH_BANG    = 8'h21;
   localparam logic [7:0] CH_UNDER   = 8'h5F;

   localparam logic [5:0] GLYPH_DIGIT_BASE = 6'd26;
   localparam logic [5:0] GLYPH_BLANK      = 6'd36;
   localparam logic [5:0] GLYPH_COLON      = 6'd37;
   localparam logic [5:0] GLYPH_BANG       = 6'd38;
   localparam logic [5:0] GLYPH_UNDER      = 6'd39;

   localparam logic [15:0] GLYPH_ROM [GLYPH_COUNT] = '{
      16'h57DA, 16'hD75C, 16'h7246, 16'hD6DC, 16'hF34E, 16'hF348, 16'h72D4, 16'hB7DA,
      16'h4924, 16'h24D4, 16'hB75A, 16'h924E, 16'hBEDA, 16'hBFFA, 16'h56D4, 16'hD748,
      16'h56F6, 16'hD75A, 16'h739C, 16'hE924, 16'hB6D4, 16'hB6A4, 16'hB6FA, 16'hB55A,
      16'hB524, 16'hE54E,
      16'h56D4, 16'h2C92, 16'hC546, 16'hC51C, 16'hB792, 16'hF11C, 16'h7354, 16'hE524,
      16'h5554, 16'h559C,
      16'h0000, 16'h0820, 16'h4904, 16'h000E
   };

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [COORD_BITS:0]   coord_wide_type;

   typedef struct packed {
      logic       new_text;
      coord_type  start_x;
      coord_type  start_y;
      logic [7:0] char_code;
   } req_type;

   typedef struct packed {
      coord_type pixel_x;
      coord_type pixel_y;
      logic      pixel_on;
      logic      last_pixel;
   } rsp_type;

   typedef struct packed {
      coord_type             origin_x;
      coord_type             origin_y;
      logic [GLYPH_BITS-1:0] glyph;
      logic                  ink_black;
      logic [1:0]            rotation;
   } job_type;

   typedef struct packed {
      logic       active;
      logic [2:0] row;
      logic [1:0] col;
   } back_status_type;

   function automatic logic [5:0] glyph_index(input logic [7:0] ch);
      logic [5:0] idx;
      if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
         idx = 6'(ch - CH_UPPER_A);
      end else if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
         idx = 6'(ch - CH_LOWER_A);
      end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
         idx = 6'(ch - CH_ZERO) + GLYPH_DIGIT_BASE;
      end else if (ch == CH_COLON) begin
         idx = GLYPH_COLON;
      end else if (ch == CH_BANG) begin
         idx = GLYPH_BANG;
      end else if (ch == CH_UNDER) begin
         idx = GLYPH_UNDER;
      end else begin
         idx = GLYPH_BLANK;
      end
      return idx;
   endfunction

   function automatic coord_wide_type widen(input coord_type v);
      return {v[COORD_BITS-1], v};
   endfunction

   function automatic coord_type sat_coord(input coord_wide_type v);
      coord_type r;
      if (v[COORD_BITS] != v[COORD_BITS-1]) begin
         r = v[COORD_BITS] ? {1'b1, {(COORD_BITS-1){1'b0}}} : {1'b0, {(COORD_BITS-1){1'b1}}};
      end else begin
         r = v[COORD_BITS-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: design/gtpg_front.sv
// Front end: config registers, cursor, glyph lookup; turns each item into a job.
// Depends on gtpg_pkg.
`default_nettype none

module gtpg_front (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_push,
   output logic                                  req_full,
   input  gtpg_pkg::req_type                     req_data,
   input  wire                                   csr_write_en,
   input  wire  [gtpg_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire  [gtpg_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   input  wire                                   job_full,
   output logic                                  job_push,
   output gtpg_pkg::job_type                     job_data
);

   logic                      ink_ff, ink_in;
   logic [1:0]                rot_ff, rot_in;
   logic [3:0]                gap_ff, gap_in;
   gtpg_pkg::coord_type       cursor_x_ff, cursor_x_in;
   gtpg_pkg::coord_type       cursor_y_ff, cursor_y_in;
   gtpg_pkg::coord_type       origin_x, origin_y;
   gtpg_pkg::coord_wide_type  adv;
   logic [15:0]               glyph_word;

   assign req_full = job_full;
   assign job_push = req_push && !job_full;

   always_comb begin
      origin_x   = req_data.new_text ? req_data.start_x : cursor_x_ff;
      origin_y   = req_data.new_text ? req_data.start_y : cursor_y_ff;
      glyph_word = gtpg_pkg::GLYPH_ROM[gtpg_pkg::glyph_index(req_data.char_code)];
      adv = {{(gtpg_pkg::COORD_BITS-3){gap_ff[3]}}, gap_ff}
            + (gtpg_pkg::COORD_BITS+1)'(4);

      job_data.origin_x  = origin_x;
      job_data.origin_y  = origin_y;
      job_data.glyph     = glyph_word[15:1];
      job_data.ink_black = ink_ff;
      job_data.rotation  = rot_ff;

      cursor_x_in = cursor_x_ff;
      cursor_y_in = cursor_y_ff;
      if (job_push) begin
         unique case (rot_ff)
            gtpg_pkg::ROT_90: begin
               cursor_x_in = origin_x;
               cursor_y_in = gtpg_pkg::sat_coord(gtpg_pkg::widen(origin_y) - adv);
            end
            gtpg_pkg::ROT_270: begin
               cursor_x_in = origin_x;
               cursor_y_in = gtpg_pkg::sat_coord(gtpg_pkg::widen(origin_y) + adv);
            end
            default: begin
               cursor_x_in = gtpg_pkg::sat_coord(gtpg_pkg::widen(origin_x) + adv);
               cursor_y_in = origin_y;
            end
         endcase
      end

      ink_in = ink_ff;
      rot_in = rot_ff;
      gap_in = gap_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            gtpg_pkg::CSR_INK_BLACK: ink_in = csr_wdata[0];
            gtpg_pkg::CSR_ROTATION:  rot_in = csr_wdata[1:0];
            gtpg_pkg::CSR_CHAR_GAP:  gap_in = csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ink_ff      <= 1'b1;
         rot_ff      <= gtpg_pkg::ROT_UPRIGHT;
         gap_ff      <= '0;
         cursor_x_ff <= '0;
         cursor_y_ff <= '0;
      end else begin
         ink_ff      <= ink_in;
         rot_ff      <= rot_in;
         gap_ff      <= gap_in;
         cursor_x_ff <= cursor_x_in;
         cursor_y_ff <= cursor_y_in;
      end
   end

endmodule

`default_nettype wire

FILE: design/gtpg_job_fifo.sv
// Short job queue between the front end and the pixel back end.
// Depends on gtpg_pkg.
`default_nettype none

module gtpg_job_fifo #(
   parameter int DEPTH = 2
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                push,
   input  gtpg_pkg::job_type  push_data,
   output logic               full,
   input  wire                pop,
   output gtpg_pkg::job_type  pop_data,
   output logic               empty
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   gtpg_pkg::job_type    mem_ff [DEPTH];
   logic [PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic                 do_push, do_pop;

   assign full     = (count_ff == CNT_BITS'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

FILE: design/gtpg_pixel_back.sv
// Back end: one glyph pixel a cycle unless stalled, into a registered output.
// Depends on gtpg_pkg.
`default_nettype none

module gtpg_pixel_back (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          job_valid,
   input  gtpg_pkg::job_type            job_data,
   output logic                         job_pop,
   output logic                         rsp_empty,
   input  wire                          rsp_pop,
   output gtpg_pkg::rsp_type            rsp_data,
   output gtpg_pkg::back_status_type    status
);

   logic                                 active_ff, active_in;
   gtpg_pkg::job_type                    job_ff, job_in;
   logic [2:0]                           row_ff, row_in;
   logic [1:0]                           col_ff, col_in;
   logic [gtpg_pkg::GLYPH_BITS-1:0]      bits_ff, bits_in;
   logic                                 out_valid_ff, out_valid_in;
   gtpg_pkg::rsp_type                    out_ff, out_in;
   logic                                 issue, is_last;
   logic [3:0]                           off_x, off_y;
   gtpg_pkg::rsp_type                    pixel;

   assign issue     = active_ff && (!out_valid_ff || rsp_pop);
   assign is_last   = (row_ff == 3'd4) && (col_ff == 2'd2);
   assign job_pop   = job_valid && (!active_ff || (issue && is_last));
   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

   assign status.active = active_ff;
   assign status.row    = row_ff;
   assign status.col    = col_ff;

   always_comb begin
      unique case (job_ff.rotation)
         gtpg_pkg::ROT_90: begin
            off_x = 4'd5 - {1'b0, row_ff};
            off_y = {2'b00, col_ff} - 4'd2;
         end
         gtpg_pkg::ROT_270: begin
            off_x = {1'b0, row_ff};
            off_y = 4'd1 - {2'b00, col_ff};
         end
         default: begin
            off_x = {2'b00, col_ff};
            off_y = {1'b0, row_ff};
         end
      endcase
      pixel.pixel_x = gtpg_pkg::sat_coord(gtpg_pkg::widen(job_ff.origin_x)
                      + {{(gtpg_pkg::COORD_BITS-3){off_x[3]}}, off_x});
      pixel.pixel_y = gtpg_pkg::sat_coord(gtpg_pkg::widen(job_ff.origin_y)
                      + {{(gtpg_pkg::COORD_BITS-3){off_y[3]}}, off_y});
      pixel.pixel_on   = ~(bits_ff[gtpg_pkg::GLYPH_BITS-1] ^ job_ff.ink_black);
      pixel.last_pixel = is_last;
   end

   always_comb begin
      active_in = active_ff;
      job_in    = job_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      bits_in   = bits_ff;
      if (job_pop) begin
         active_in = 1'b1;
         job_in    = job_data;
         row_in    = '0;
         col_in    = '0;
         bits_in   = job_data.glyph;
      end else if (issue && is_last) begin
         active_in = 1'b0;
      end else if (issue) begin
         bits_in = {bits_ff[gtpg_pkg::GLYPH_BITS-2:0], 1'b0};
         if (col_ff == 2'd2) begin
            col_in = '0;
            row_in = row_ff + 3'd1;
         end else begin
            col_in = col_ff + 2'd1;
         end
      end

      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (issue) begin
         out_valid_in = 1'b1;
         out_in       = pixel;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
         row_ff       <= '0;
         col_ff       <= '0;
      end else begin
         active_ff    <= active_in;
         out_valid_ff <= out_valid_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff  <= job_in;
      bits_ff <= bits_in;
      out_ff  <= out_in;
   end

endmodule

`default_nettype wire

FILE: design/glyph_text_pixel_generator_top.sv
// Top level of the 3x5 glyph text pixel generator.
// Depends on gtpg_pkg, gtpg_front, gtpg_job_fifo, gtpg_pixel_back and the defines header.
//
// Usage:
//  - Request queue: push a character item (new_text, start_x, start_y, char_code)
//    while req_full is low. new_text starts the text at the given position,
//    otherwise the kept cursor is used.
//  - Result queue: while rsp_empty is low, rsp_data holds the oldest pixel write;
//    pop takes it. Each character gives 15 items, the last with last_pixel set.
//  - CSR port: csr_write_en with csr_index 0 ink_black, 1 rotation, 2 char_gap.
//    Write only while the block is idle.
//  - Path: an accepted item passes the job queue into the back end's job register.
//  - Throughput: one pixel per cycle from the back end scan while the result
//    queue is not stalled; a queued next character follows back to back.
//  - Up to QUEUE_DEPTH characters wait in the job queue while the back end scans.
//  - A stalled result queue holds its item; the back end stops, the job queue
//    fills and then req_full rises.
//  - Reset clears queues and cursor (0,0); ink_black=1, rotation=0, char_gap=0.
`include "glyph_text_pixel_generator_top_defines.svh"
`default_nettype none

module glyph_text_pixel_generator_top #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_push,
   output logic                                 req_full,
   input  gtpg_pkg::req_type                    req_data,
   output logic                                 rsp_empty,
   input  wire                                  rsp_pop,
   output gtpg_pkg::rsp_type                    rsp_data,
   input  wire                                  csr_write_en,
   input  wire  [gtpg_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire  [gtpg_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   logic                        job_push, job_full, job_pop, job_empty;
   gtpg_pkg::job_type           job_in_data, job_out_data;
   gtpg_pkg::back_status_type   back_status;
   logic                        accept_item, rsp_mid_char;

   assign accept_item  = req_push && !req_full;
   assign rsp_mid_char = !rsp_empty && !rsp_data.last_pixel;

   gtpg_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_data     (req_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .job_full     (job_full),
      .job_push     (job_push),
      .job_data     (job_in_data)
   );

   gtpg_job_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_job_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_in_data),
      .full      (job_full),
      .pop       (job_pop),
      .pop_data  (job_out_data),
      .empty     (job_empty)
   );

   gtpg_pixel_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (!job_empty),
      .job_data  (job_out_data),
      .job_pop   (job_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .status    (back_status)
   );

   `GTPG_ASSERT_IMPLY(a_job_no_overflow, clock, reset, job_push, !job_full)
   `GTPG_ASSERT_IMPLY(a_mid_char_active, clock, reset, rsp_mid_char, back_status.active)
   `GTPG_ASSERT_NEXT(a_accept_queued, clock, reset, accept_item, !job_empty || back_status.active)

endmodule

`default_nettype wire
